// File: src/clre_pkg.sv
package clre_pkg;

  // Fixed field widths and store sizes
  localparam int NET_W    = 6;
  localparam int COL_W    = 6;
  localparam int LVL_W    = 3;
  localparam int TRK_W    = 6;
  localparam int CNT_W    = 7;
  localparam int NUM_NETS = 64;
  localparam int NUM_COLS = 64;
  localparam int NUM_LVLS = 8;

  localparam logic [NET_W-1:0] NET_LAST  = NET_W'(NUM_NETS - 1);
  localparam logic [LVL_W-1:0] PROP_LAST = LVL_W'(NUM_LVLS - 2);

  // Region codes
  localparam logic [1:0] REGION_NONE   = 2'd0;
  localparam logic [1:0] REGION_TOP    = 2'd1;
  localparam logic [1:0] REGION_BOTTOM = 2'd2;
  localparam logic [1:0] REGION_CHAN   = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD_B, ST_PROP,
    ST_S_SCAN, ST_S_KEY, ST_S_CMPA, ST_S_CMPB, ST_S_PLACE,
    ST_B_FETCH, ST_B_NET, ST_B_DATA, ST_B_TRY,
    ST_C_CHECK, ST_C_FETCH, ST_C_NET, ST_C_DATA,
    ST_E_SCAN, ST_E_WAIT, ST_CLEAR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD_A, OP_LOAD_B, OP_PROP,
    OP_S_SCAN, OP_S_KEY, OP_S_CMPA, OP_S_CMPB, OP_S_PLACE,
    OP_B_FETCH, OP_B_NET, OP_B_DATA, OP_B_TRY,
    OP_C_CHECK, OP_C_FETCH, OP_C_NET, OP_C_DATA,
    OP_E_SCAN, OP_E_WAIT, OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   side;   // 0 top boundary pass, 1 bottom boundary pass
  } cmd_t;

  typedef struct packed {
    logic last_col;
    logic prop_done;
    logic cur_seen;
    logic idx_last;
    logic k_zero;
    logic k_one;
    logic precedes;
    logic k_end;
    logic skip;
    logic fit;
    logic j_zero;
    logic all_routed;
    logic progress;
    logic out_free;
    logic last_net;
  } sts_t;

endpackage

// File: src/channel_left_edge_router_unit.sv
// Constrained left-edge channel router.
// Input channel (in_valid / in_stall): one transfer per channel column, carrying
// the top and bottom pin nets and the top and bottom boundary levels. A column
// loads through the OP_LOAD_A and OP_LOAD_B steps; in_stall is high while a column or a routing run is
// in progress. Columns beyond 64 are dropped but their last-column flag counts.
// The transfer with in_last_column set starts a routing run: level fill,
// insertion sort of the seen nets, top and bottom boundary passes (each net
// tries its boundary levels from the highest usable level down) and left-edge
// channel passes. The run is bounded by the net memories it walks.
// Result channel (out_valid / out_stall): one transfer per seen net, in
// ascending net order, last one flagged with out_last_result. Each result is
// fetched from the net memories; a stalled result holds in the output register
// and the run waits on it. After the last result the block clears its net and
// grid state and takes a new channel.
// Reset (rst_n low, synchronous) empties the channel and drops any result.
module channel_left_edge_router_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [clre_pkg::NET_W-1:0] in_top_net,
  input  logic [clre_pkg::NET_W-1:0] in_bottom_net,
  input  logic [clre_pkg::LVL_W-1:0] in_top_boundary_level,
  input  logic [clre_pkg::LVL_W-1:0] in_bottom_boundary_level,
  input  logic                       in_last_column,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [clre_pkg::NET_W-1:0] out_net_number,
  output logic [1:0]                 out_region,
  output logic [clre_pkg::TRK_W-1:0] out_track_number,
  output logic [clre_pkg::COL_W-1:0] out_left_column,
  output logic [clre_pkg::COL_W-1:0] out_right_column,
  output logic [clre_pkg::TRK_W-1:0] out_density,
  output logic                       out_cycle_error,
  output logic                       out_last_result
);
  import clre_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  clre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and routing datapath
  clre_dp u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .sts                      (sts),
    .in_top_net               (in_top_net),
    .in_bottom_net            (in_bottom_net),
    .in_top_boundary_level    (in_top_boundary_level),
    .in_bottom_boundary_level (in_bottom_boundary_level),
    .in_last_column           (in_last_column),
    .out_stall                (out_stall),
    .out_valid                (out_valid),
    .out_net_number           (out_net_number),
    .out_region               (out_region),
    .out_track_number         (out_track_number),
    .out_left_column          (out_left_column),
    .out_right_column         (out_right_column),
    .out_density              (out_density),
    .out_cycle_error          (out_cycle_error),
    .out_last_result          (out_last_result)
  );

endmodule

// File: src/clre_ctrl.sv
module clre_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  clre_pkg::sts_t sts,
  output clre_pkg::cmd_t cmd
);
  import clre_pkg::*;

  state_t state_r, state_nxt;
  logic   side_r, side_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    cmd.side  = side_r;
    cmd.op    = OP_NONE;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD_A;
          state_nxt = ST_LOAD_B;
        end
      end
      ST_LOAD_B: begin
        cmd.op    = OP_LOAD_B;
        state_nxt = sts.last_col ? ST_PROP : ST_IDLE;
      end
      ST_PROP: begin
        cmd.op = OP_PROP;
        if (sts.prop_done) begin
          state_nxt = ST_S_SCAN;
          side_nxt  = 1'b0;
        end
      end
      ST_S_SCAN: begin
        cmd.op = OP_S_SCAN;
        if (sts.cur_seen)      state_nxt = ST_S_KEY;
        else if (sts.idx_last) state_nxt = ST_B_FETCH;
      end
      ST_S_KEY: begin
        cmd.op    = OP_S_KEY;
        state_nxt = sts.k_zero ? ST_S_PLACE : ST_S_CMPA;
      end
      ST_S_CMPA: begin
        cmd.op    = OP_S_CMPA;
        state_nxt = ST_S_CMPB;
      end
      ST_S_CMPB: begin
        cmd.op    = OP_S_CMPB;
        state_nxt = (sts.precedes && !sts.k_one) ? ST_S_CMPA : ST_S_PLACE;
      end
      ST_S_PLACE: begin
        cmd.op    = OP_S_PLACE;
        state_nxt = sts.idx_last ? ST_B_FETCH : ST_S_SCAN;
      end
      ST_B_FETCH: begin
        cmd.op = OP_B_FETCH;
        if (sts.k_end) begin
          if (side_r) state_nxt = ST_C_CHECK;
          else        side_nxt  = 1'b1;
        end else begin
          state_nxt = ST_B_NET;
        end
      end
      ST_B_NET: begin
        cmd.op    = OP_B_NET;
        state_nxt = ST_B_DATA;
      end
      ST_B_DATA: begin
        cmd.op    = OP_B_DATA;
        state_nxt = sts.skip ? ST_B_FETCH : ST_B_TRY;
      end
      ST_B_TRY: begin
        cmd.op = OP_B_TRY;
        if (sts.fit || sts.j_zero) state_nxt = ST_B_FETCH;
      end
      ST_C_CHECK: begin
        cmd.op    = OP_C_CHECK;
        state_nxt = sts.all_routed ? ST_E_SCAN : ST_C_FETCH;
      end
      ST_C_FETCH: begin
        cmd.op = OP_C_FETCH;
        if (sts.k_end) state_nxt = sts.progress ? ST_C_CHECK : ST_E_SCAN;
        else           state_nxt = ST_C_NET;
      end
      ST_C_NET: begin
        cmd.op    = OP_C_NET;
        state_nxt = ST_C_DATA;
      end
      ST_C_DATA: begin
        cmd.op    = OP_C_DATA;
        state_nxt = ST_C_FETCH;
      end
      ST_E_SCAN: begin
        cmd.op = OP_E_SCAN;
        if (sts.cur_seen)      state_nxt = ST_E_WAIT;
        else if (sts.idx_last) state_nxt = ST_CLEAR;
      end
      ST_E_WAIT: begin
        cmd.op = OP_E_WAIT;
        if (sts.out_free) state_nxt = sts.last_net ? ST_CLEAR : ST_E_SCAN;
      end
      ST_CLEAR: begin
        cmd.op    = OP_CLEAR;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: src/clre_dp.sv
module clre_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  clre_pkg::cmd_t               cmd,
  output clre_pkg::sts_t               sts,
  input  logic [clre_pkg::NET_W-1:0]   in_top_net,
  input  logic [clre_pkg::NET_W-1:0]   in_bottom_net,
  input  logic [clre_pkg::LVL_W-1:0]   in_top_boundary_level,
  input  logic [clre_pkg::LVL_W-1:0]   in_bottom_boundary_level,
  input  logic                         in_last_column,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [clre_pkg::NET_W-1:0]   out_net_number,
  output logic [1:0]                   out_region,
  output logic [clre_pkg::TRK_W-1:0]   out_track_number,
  output logic [clre_pkg::COL_W-1:0]   out_left_column,
  output logic [clre_pkg::COL_W-1:0]   out_right_column,
  output logic [clre_pkg::TRK_W-1:0]   out_density,
  output logic                         out_cycle_error,
  output logic                         out_last_result
);
  import clre_pkg::*;

  // Memories
  logic [COL_W-1:0]      left_mem  [NUM_NETS];
  logic [COL_W-1:0]      right_mem [NUM_NETS];
  logic [NUM_NETS-1:0]   mat_mem   [NUM_NETS];   // row t: bottom nets below t
  logic [NUM_NETS-1:0]   matt_mem  [NUM_NETS];   // row b: top nets above b
  logic [NET_W-1:0]      sort_mem  [NUM_NETS];
  logic [TRK_W+1:0]      rt_mem    [NUM_NETS];   // {region, track}

  logic [COL_W-1:0]    left_rd, right_rd;
  logic [NUM_NETS-1:0] mat_rd, matt_rd;
  logic                mat_vq, matt_vq;
  logic [NET_W-1:0]    sort_rd;
  logic [TRK_W+1:0]    rt_rd;

  logic [NET_W-1:0]    lr_ra, mat_ra, matt_ra, sort_ra;
  logic                l_we, r_we, mat_we, sort_we, rt_we;
  logic [NET_W-1:0]    lr_wa, mat_wa, matt_wa, sort_wa, rt_wa;
  logic [COL_W-1:0]    lr_wd;
  logic [NUM_NETS-1:0] mat_wd, matt_wd;
  logic [NET_W-1:0]    sort_wd;
  logic [TRK_W+1:0]    rt_wd;

  // Control and working registers
  logic [CNT_W-1:0]    col_cnt_r, col_cnt_nxt;
  logic [LVL_W-1:0]    tprev_r, tprev_nxt, bprev_r, bprev_nxt;
  logic [LVL_W:0]      tsize_r, tsize_nxt, bsize_r, bsize_nxt;
  logic [NUM_NETS-1:0] seen_r, seen_nxt, routed_r, routed_nxt;
  logic [NUM_NETS-1:0] mvld_r, mvld_nxt, mtvld_r, mtvld_nxt;
  logic [NUM_COLS-1:0] tgrid_r [NUM_LVLS];
  logic [NUM_COLS-1:0] tgrid_nxt [NUM_LVLS];
  logic [NUM_COLS-1:0] bgrid_r [NUM_LVLS];
  logic [NUM_COLS-1:0] bgrid_nxt [NUM_LVLS];
  logic [NET_W-1:0]    tn_r, tn_nxt, bn_r, bn_nxt;
  logic                last_r, last_nxt, inr_r, inr_nxt;
  logic [NET_W-1:0]    n_r, n_nxt, m_r, m_nxt, cur_n_r, cur_n_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt, cnt_r, cnt_nxt, rcnt_r, rcnt_nxt, tracks_r, tracks_nxt;
  logic [LVL_W-1:0]    j_r, j_nxt;
  logic [COL_W-1:0]    key_l_r, key_l_nxt, key_r_r, key_r_nxt;
  logic [COL_W-1:0]    cur_l_r, cur_l_nxt, cur_r_r, cur_r_nxt;
  logic [NUM_COLS-1:0] mask_r, mask_nxt;
  logic [COL_W-1:0]    water_r, water_nxt;
  logic                wvld_r, wvld_nxt, prog_r, prog_nxt, err_r, err_nxt;

  // Output register
  logic                ov_r, ov_nxt;
  logic [NET_W-1:0]    o_net_r, o_net_nxt;
  logic [1:0]          o_reg_r, o_reg_nxt;
  logic [TRK_W-1:0]    o_trk_r, o_trk_nxt, o_den_r, o_den_nxt;
  logic [COL_W-1:0]    o_l_r, o_l_nxt, o_r_r, o_r_nxt;
  logic                o_err_r, o_err_nxt, o_last_r, o_last_nxt;

  // Derived values
  logic [NUM_NETS-1:0] mat_q, matt_q, seen_above;
  logic [COL_W-1:0]    col;
  logic                in_range, below_ok, above_ok, cok, c_route, b_fit;
  logic [NUM_COLS-1:0] mask_new, grid_row;
  logic [LVL_W-1:0]    size_sel_m2;
  logic [LVL_W:0]      size_sel;
  logic [CNT_W-1:0]    k_m1, k_m2;

  assign mat_q      = mat_vq  ? mat_rd  : '0;
  assign matt_q     = matt_vq ? matt_rd : '0;
  assign col        = col_cnt_r[COL_W-1:0];
  assign in_range   = (col_cnt_r < CNT_W'(NUM_COLS));
  assign below_ok   = ((mat_q & ~routed_r) == '0);
  assign above_ok   = ((matt_q & ~routed_r) == '0);
  assign cok        = cmd.side ? below_ok : above_ok;
  assign mask_new   = ({NUM_COLS{1'b1}} << left_rd) & ({NUM_COLS{1'b1}} >> (~right_rd));
  assign size_sel   = cmd.side ? bsize_r : tsize_r;
  assign size_sel_m2 = LVL_W'(size_sel - (LVL_W+1)'(2));
  assign grid_row   = cmd.side ? bgrid_r[j_r] : tgrid_r[j_r];
  assign b_fit      = ((grid_row & mask_r) == '0);
  assign c_route    = !routed_r[cur_n_r] && (!wvld_r || (water_r < left_rd)) && below_ok;
  assign seen_above = (seen_r >> n_r) >> 1;
  assign k_m1       = k_r - CNT_W'(1);
  assign k_m2       = k_r - CNT_W'(2);

  // Status to the controller
  always_comb begin
    sts.last_col   = last_r;
    sts.prop_done  = (j_r == PROP_LAST);
    sts.cur_seen   = seen_r[n_r];
    sts.idx_last   = (n_r == NET_LAST);
    sts.k_zero     = (k_r == '0);
    sts.k_one      = (k_r == CNT_W'(1));
    sts.precedes   = (key_l_r < left_rd) ||
                     ((key_l_r == left_rd) && ((key_r_r < right_rd) ||
                     ((key_r_r == right_rd) && (n_r < m_r))));
    sts.k_end      = (k_r == cnt_r);
    sts.skip       = routed_r[cur_n_r] || !cok || (size_sel < (LVL_W+1)'(2));
    sts.fit        = b_fit;
    sts.j_zero     = (j_r == '0);
    sts.all_routed = (rcnt_r == cnt_r);
    sts.progress   = prog_r;
    sts.out_free   = !ov_r || !out_stall;
    sts.last_net   = (seen_above == '0);
  end

  // Memory ports
  always_comb begin
    lr_ra   = n_r;
    mat_ra  = sort_rd;
    matt_ra = sort_rd;
    sort_ra = k_r[NET_W-1:0];
    l_we = 1'b0; r_we = 1'b0; lr_wa = tn_r; lr_wd = col;
    mat_we = 1'b0; mat_wa = tn_r; matt_wa = bn_r;
    mat_wd  = mat_q  | (NUM_NETS'(1) << bn_r);
    matt_wd = matt_q | (NUM_NETS'(1) << tn_r);
    sort_we = 1'b0; sort_wa = k_r[NET_W-1:0]; sort_wd = n_r;
    rt_we = 1'b0; rt_wa = cur_n_r;
    rt_wd = {(cmd.side ? REGION_BOTTOM : REGION_TOP), TRK_W'(j_r)};
    case (cmd.op)
      OP_LOAD_A: begin
        mat_ra  = in_top_net;
        matt_ra = in_bottom_net;
        lr_wa   = in_top_net;
        l_we    = in_range && (in_top_net != '0) && !seen_r[in_top_net];
        r_we    = in_range && (in_top_net != '0);
      end
      OP_LOAD_B: begin
        lr_wa  = bn_r;
        l_we   = inr_r && (bn_r != '0) && !seen_r[bn_r];
        r_we   = inr_r && (bn_r != '0);
        mat_we = inr_r && (tn_r != '0) && (bn_r != '0) && (tn_r != bn_r);
      end
      OP_S_KEY:   sort_ra = k_m1[NET_W-1:0];
      OP_S_CMPA:  lr_ra   = sort_rd;
      OP_S_CMPB: begin
        sort_ra = k_m2[NET_W-1:0];
        sort_we = sts.precedes;
        sort_wd = m_r;
      end
      OP_S_PLACE: sort_we = 1'b1;
      OP_B_NET, OP_C_NET: lr_ra = sort_rd;
      OP_B_TRY:   rt_we = b_fit;
      OP_C_DATA: begin
        rt_we = c_route;
        rt_wd = {REGION_CHAN, TRK_W'(tracks_r + CNT_W'(1))};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (l_we)    left_mem[lr_wa]   <= lr_wd;
    if (r_we)    right_mem[lr_wa]  <= lr_wd;
    if (mat_we)  mat_mem[mat_wa]   <= mat_wd;
    if (mat_we)  matt_mem[matt_wa] <= matt_wd;
    if (sort_we) sort_mem[sort_wa] <= sort_wd;
    if (rt_we)   rt_mem[rt_wa]     <= rt_wd;
    left_rd  <= left_mem[lr_ra];
    right_rd <= right_mem[lr_ra];
    mat_rd   <= mat_mem[mat_ra];
    matt_rd  <= matt_mem[matt_ra];
    mat_vq   <= mvld_r[mat_ra];
    matt_vq  <= mtvld_r[matt_ra];
    sort_rd  <= sort_mem[sort_ra];
    rt_rd    <= rt_mem[n_r];
  end

  // Boundary grids: column marks, level fill, track claims and clear
  always_comb begin
    for (int m = 0; m < NUM_LVLS; m++) begin
      tgrid_nxt[m] = tgrid_r[m];
      bgrid_nxt[m] = bgrid_r[m];
    end
    case (cmd.op)
      OP_LOAD_A: begin
        if (in_range) begin
          tgrid_nxt[in_top_boundary_level][col] = 1'b1;
          bgrid_nxt[in_bottom_boundary_level][col] = 1'b1;
          if ((col != '0) && (tprev_r != in_top_boundary_level))
            tgrid_nxt[tprev_r][col] = 1'b1;
          if ((col != '0) && (bprev_r != in_bottom_boundary_level))
            bgrid_nxt[bprev_r][col] = 1'b1;
        end
      end
      OP_PROP: begin
        for (int m = 1; m < NUM_LVLS; m++) begin
          if ((m - 1 == int'(j_r)) && (m + 1 < int'(tsize_r)))
            tgrid_nxt[m] = tgrid_r[m] | tgrid_r[m-1];
          if ((m - 1 == int'(j_r)) && (m + 1 < int'(bsize_r)))
            bgrid_nxt[m] = bgrid_r[m] | bgrid_r[m-1];
        end
      end
      OP_B_TRY: begin
        if (b_fit) begin
          for (int m = 0; m < NUM_LVLS; m++) begin
            if (cmd.side) begin
              if (m == int'(j_r)) bgrid_nxt[m] = bgrid_r[m] | mask_r;
              if ((m > int'(j_r)) && (m + 1 < int'(bsize_r))) begin
                bgrid_nxt[m][cur_l_r] = 1'b1;
                bgrid_nxt[m][cur_r_r] = 1'b1;
              end
            end else begin
              if (m == int'(j_r)) tgrid_nxt[m] = tgrid_r[m] | mask_r;
              if ((m > int'(j_r)) && (m + 1 < int'(tsize_r))) begin
                tgrid_nxt[m][cur_l_r] = 1'b1;
                tgrid_nxt[m][cur_r_r] = 1'b1;
              end
            end
          end
        end
      end
      OP_CLEAR: begin
        for (int m = 0; m < NUM_LVLS; m++) begin
          tgrid_nxt[m] = '0;
          bgrid_nxt[m] = '0;
        end
      end
      default: ;
    endcase
  end

  // Sequencing registers
  always_comb begin
    col_cnt_nxt = col_cnt_r; tprev_nxt = tprev_r; bprev_nxt = bprev_r;
    tsize_nxt = tsize_r; bsize_nxt = bsize_r;
    seen_nxt = seen_r; routed_nxt = routed_r; mvld_nxt = mvld_r; mtvld_nxt = mtvld_r;
    tn_nxt = tn_r; bn_nxt = bn_r; last_nxt = last_r; inr_nxt = inr_r;
    n_nxt = n_r; m_nxt = m_r; cur_n_nxt = cur_n_r;
    k_nxt = k_r; cnt_nxt = cnt_r; rcnt_nxt = rcnt_r; tracks_nxt = tracks_r;
    j_nxt = j_r; key_l_nxt = key_l_r; key_r_nxt = key_r_r;
    cur_l_nxt = cur_l_r; cur_r_nxt = cur_r_r; mask_nxt = mask_r;
    water_nxt = water_r; wvld_nxt = wvld_r; prog_nxt = prog_r; err_nxt = err_r;
    ov_nxt = ov_r && out_stall;
    o_net_nxt = o_net_r; o_reg_nxt = o_reg_r; o_trk_nxt = o_trk_r; o_den_nxt = o_den_r;
    o_l_nxt = o_l_r; o_r_nxt = o_r_r; o_err_nxt = o_err_r; o_last_nxt = o_last_r;
    case (cmd.op)
      OP_LOAD_A: begin
        tn_nxt   = in_top_net;
        bn_nxt   = in_bottom_net;
        last_nxt = in_last_column;
        inr_nxt  = in_range;
        if (in_range) begin
          if (in_top_net != '0) seen_nxt[in_top_net] = 1'b1;
          tprev_nxt = in_top_boundary_level;
          bprev_nxt = in_bottom_boundary_level;
          if ({1'b0, in_top_boundary_level} >= tsize_r)
            tsize_nxt = {1'b0, in_top_boundary_level} + (LVL_W+1)'(1);
          if ({1'b0, in_bottom_boundary_level} >= bsize_r)
            bsize_nxt = {1'b0, in_bottom_boundary_level} + (LVL_W+1)'(1);
        end
      end
      OP_LOAD_B: begin
        if (inr_r) begin
          col_cnt_nxt = col_cnt_r + CNT_W'(1);
          if (bn_r != '0) seen_nxt[bn_r] = 1'b1;
          if (mat_we) begin
            mvld_nxt[tn_r]  = 1'b1;
            mtvld_nxt[bn_r] = 1'b1;
          end
        end
        j_nxt = '0;
      end
      OP_PROP: begin
        j_nxt = j_r + LVL_W'(1);
        n_nxt = NET_W'(1);
      end
      OP_S_SCAN: begin
        if (seen_r[n_r]) k_nxt = cnt_r;
        else if (n_r == NET_LAST) k_nxt = '0;
        else n_nxt = n_r + NET_W'(1);
      end
      OP_S_KEY: begin
        key_l_nxt = left_rd;
        key_r_nxt = right_rd;
      end
      OP_S_CMPA: m_nxt = sort_rd;
      OP_S_CMPB: if (sts.precedes) k_nxt = k_m1;
      OP_S_PLACE: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (n_r == NET_LAST) k_nxt = '0;
        else n_nxt = n_r + NET_W'(1);
      end
      OP_B_FETCH: if (sts.k_end) k_nxt = '0;
      OP_B_NET, OP_C_NET: cur_n_nxt = sort_rd;
      OP_B_DATA: begin
        cur_l_nxt = left_rd;
        cur_r_nxt = right_rd;
        mask_nxt  = mask_new;
        j_nxt     = size_sel_m2;
        if (sts.skip) k_nxt = k_r + CNT_W'(1);
      end
      OP_B_TRY: begin
        if (b_fit) begin
          routed_nxt[cur_n_r] = 1'b1;
          rcnt_nxt = rcnt_r + CNT_W'(1);
          k_nxt    = k_r + CNT_W'(1);
        end else if (j_r == '0) begin
          k_nxt = k_r + CNT_W'(1);
        end else begin
          j_nxt = j_r - LVL_W'(1);
        end
      end
      OP_C_CHECK: begin
        if (rcnt_r == cnt_r) begin
          n_nxt = NET_W'(1);
        end else begin
          k_nxt = '0; wvld_nxt = 1'b0; prog_nxt = 1'b0;
        end
      end
      OP_C_FETCH: begin
        if (sts.k_end) begin
          if (prog_r) begin
            tracks_nxt = tracks_r + CNT_W'(1);
          end else begin
            err_nxt = 1'b1;
            n_nxt   = NET_W'(1);
          end
        end
      end
      OP_C_DATA: begin
        k_nxt = k_r + CNT_W'(1);
        if (c_route) begin
          routed_nxt[cur_n_r] = 1'b1;
          rcnt_nxt  = rcnt_r + CNT_W'(1);
          water_nxt = right_rd;
          wvld_nxt  = 1'b1;
          prog_nxt  = 1'b1;
        end
      end
      OP_E_SCAN: if (!seen_r[n_r]) n_nxt = n_r + NET_W'(1);
      OP_E_WAIT: begin
        if (sts.out_free) begin
          ov_nxt     = 1'b1;
          o_net_nxt  = n_r;
          o_reg_nxt  = routed_r[n_r] ? rt_rd[TRK_W+1:TRK_W] : REGION_NONE;
          o_trk_nxt  = routed_r[n_r] ? rt_rd[TRK_W-1:0] : '0;
          o_l_nxt    = left_rd;
          o_r_nxt    = right_rd;
          o_den_nxt  = tracks_r[TRK_W-1:0];
          o_err_nxt  = err_r;
          o_last_nxt = sts.last_net;
          n_nxt      = n_r + NET_W'(1);
        end
      end
      OP_CLEAR: begin
        col_cnt_nxt = '0; tsize_nxt = '0; bsize_nxt = '0;
        seen_nxt = '0; routed_nxt = '0; mvld_nxt = '0; mtvld_nxt = '0;
        cnt_nxt = '0; rcnt_nxt = '0; tracks_nxt = '0; err_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0; tsize_r <= '0; bsize_r <= '0;
      seen_r <= '0; routed_r <= '0; mvld_r <= '0; mtvld_r <= '0;
      cnt_r <= '0; rcnt_r <= '0; tracks_r <= '0; err_r <= 1'b0;
      last_r <= 1'b0; ov_r <= 1'b0;
      for (int m = 0; m < NUM_LVLS; m++) begin
        tgrid_r[m] <= '0;
        bgrid_r[m] <= '0;
      end
    end else begin
      col_cnt_r <= col_cnt_nxt; tsize_r <= tsize_nxt; bsize_r <= bsize_nxt;
      seen_r <= seen_nxt; routed_r <= routed_nxt; mvld_r <= mvld_nxt; mtvld_r <= mtvld_nxt;
      cnt_r <= cnt_nxt; rcnt_r <= rcnt_nxt; tracks_r <= tracks_nxt; err_r <= err_nxt;
      last_r <= last_nxt; ov_r <= ov_nxt;
      for (int m = 0; m < NUM_LVLS; m++) begin
        tgrid_r[m] <= tgrid_nxt[m];
        bgrid_r[m] <= bgrid_nxt[m];
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    tprev_r <= tprev_nxt; bprev_r <= bprev_nxt;
    tn_r <= tn_nxt; bn_r <= bn_nxt; inr_r <= inr_nxt;
    n_r <= n_nxt; m_r <= m_nxt; cur_n_r <= cur_n_nxt;
    k_r <= k_nxt; j_r <= j_nxt;
    key_l_r <= key_l_nxt; key_r_r <= key_r_nxt;
    cur_l_r <= cur_l_nxt; cur_r_r <= cur_r_nxt; mask_r <= mask_nxt;
    water_r <= water_nxt; wvld_r <= wvld_nxt; prog_r <= prog_nxt;
    o_net_r <= o_net_nxt; o_reg_r <= o_reg_nxt; o_trk_r <= o_trk_nxt; o_den_r <= o_den_nxt;
    o_l_r <= o_l_nxt; o_r_r <= o_r_nxt; o_err_r <= o_err_nxt; o_last_r <= o_last_nxt;
  end

  assign out_valid        = ov_r;
  assign out_net_number   = o_net_r;
  assign out_region       = o_reg_r;
  assign out_track_number = o_trk_r;
  assign out_left_column  = o_l_r;
  assign out_right_column = o_r_r;
  assign out_density      = o_den_r;
  assign out_cycle_error  = o_err_r;
  assign out_last_result  = o_last_r;

endmodule

// File: src/clre_checker.sv
module clre_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [clre_pkg::NET_W-1:0] in_top_net,
  input logic [clre_pkg::NET_W-1:0] in_bottom_net,
  input logic [clre_pkg::LVL_W-1:0] in_top_boundary_level,
  input logic [clre_pkg::LVL_W-1:0] in_bottom_boundary_level,
  input logic                       in_last_column,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [clre_pkg::NET_W-1:0] out_net_number,
  input logic [1:0]                 out_region,
  input logic [clre_pkg::TRK_W-1:0] out_track_number,
  input logic [clre_pkg::COL_W-1:0] out_left_column,
  input logic [clre_pkg::COL_W-1:0] out_right_column,
  input logic [clre_pkg::TRK_W-1:0] out_density,
  input logic                       out_cycle_error,
  input logic                       out_last_result
);
  import clre_pkg::*;

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its net and track number
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_net_number) && $stable(out_track_number))
    else $error("stalled result changed");

  // Results name a real net with an ordered span
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_net_number != '0) && (out_left_column <= out_right_column))
    else $error("bad net or span");

  // Channel tracks lie within the density, unrouted nets carry no track
  a_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_region == REGION_CHAN) && (out_track_number != '0) &&
                   (out_track_number <= out_density)) ||
                  ((out_region == REGION_NONE) && (out_track_number == '0)) ||
                  (out_region == REGION_TOP) || (out_region == REGION_BOTTOM))
    else $error("track out of range");

endmodule

bind channel_left_edge_router_unit clre_checker u_clre_checker (.*);
